@@ src/fcf_pkg.sv @@
// Package for the framed complex FIR filter: shared widths, codes and word types.
// No dependencies; every other file of the block imports it.
package fcf_pkg;

   localparam int OUT_BITS   = 24;
   localparam int OUT_SHIFT  = 16;
   localparam int FRAME_W    = 16;
   localparam int TAPCNT_W   = 6;
   localparam int COEF_IDX_W = 5;
   localparam int REG_IDX_W  = 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FRAME_W-1:0]  FRAME_LEN_RESET = 16'd1000;
   localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 6'd24;

   // request word kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   // register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 1'b1;

   typedef struct packed {
      logic valid;
      logic last;
   } fcf_tag_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] out_i;
      logic signed [OUT_BITS-1:0] out_q;
      logic                       frame_last;
   } fcf_out_type;

endpackage

@@ src/fcf_req_if.sv @@
// Request channel of the framed complex FIR filter: sample and coefficient words.
// Depends on fcf_pkg.
interface fcf_req_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18
);
   import fcf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [COEF_IDX_W-1:0]         coef_index;
   logic signed [COEF_BITS-1:0]   coef_value;
   logic signed [SAMPLE_BITS-1:0] sample_i;
   logic signed [SAMPLE_BITS-1:0] sample_q;

   modport source (
      output valid, req_type, coef_index, coef_value, sample_i, sample_q,
      input  ready
   );

   modport sink (
      input  valid, req_type, coef_index, coef_value, sample_i, sample_q,
      output ready
   );

endinterface

@@ src/fcf_rsp_if.sv @@
// Response channel of the framed complex FIR filter: filtered I/Q words.
// Depends on fcf_pkg.
interface fcf_rsp_if;
   import fcf_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] out_i;
   logic signed [OUT_BITS-1:0] out_q;
   logic                       frame_last;

   modport source (
      output valid, out_i, out_q, frame_last,
      input  ready
   );

   modport sink (
      input  valid, out_i, out_q, frame_last,
      output ready
   );

endinterface

@@ src/framed_complex_fir_filter.sv @@
// Framed complex FIR filter: a sample word's result passes the tap cell product registers,
// the adder tree levels and the output FIFO; coefficient words yield none. LVL = clog2(MAX_TAPS).
// Throughput is one word per cycle while ready is high; the output FIFO of 2^clog2(LVL+4)
// words sets how many results may be outstanding, so ready drops only while the sink stalls.
// Synchronous active-high reset clears history, taps, frame position and the FIFO,
// and loads frame_len = 1000 and tap_count = 24; no clearing pass is needed.
module framed_complex_fir_filter #(
   parameter int MAX_TAPS    = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18
) (
   input  logic                              clock,
   input  logic                              reset,
   fcf_req_if.sink                           req_bus,
   fcf_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fcf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fcf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fcf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import fcf_pkg::*;

   localparam int PW      = SAMPLE_BITS + COEF_BITS;
   localparam int LVL     = $clog2(MAX_TAPS);
   localparam int LEAVES  = 1 << LVL;
   localparam int ACC_RAW = PW + LVL;
   localparam int ACC_MIN = OUT_SHIFT + OUT_BITS;
   localparam int ACC_W   = (ACC_RAW < ACC_MIN) ? ACC_MIN : ((ACC_RAW > 64) ? 64 : ACC_RAW);
   localparam int FD      = 1 << $clog2(LVL + 4);
   localparam int PTR_W   = $clog2(FD);
   localparam int OCC_W   = $clog2(FD + 1);

   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [OUT_BITS-1:0] shift_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] s;
      s = acc >>> OUT_SHIFT;
      if (s > SAT_HI) begin
         return SAT_HI[OUT_BITS-1:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[OUT_BITS-1:0];
      end
      return s[OUT_BITS-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [FRAME_W-1:0]  frame_len_ff;
   logic [TAPCNT_W-1:0] tap_count_ff;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= FRAME_LEN_RESET;
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_FRAME_LEN: frame_len_ff <= pwdata[FRAME_W-1:0];
            REG_TAP_COUNT: tap_count_ff <= pwdata[TAPCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FRAME_LEN: prdata = CSR_DATA_W'(frame_len_ff);
         REG_TAP_COUNT: prdata = CSR_DATA_W'(tap_count_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------- request side ----------------
   logic               req_fire, sample_acc, coef_acc;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [FRAME_W-1:0] frame_pos_ff, frame_pos_in;
   logic [FRAME_W:0]   frame_span, pos_next;
   logic               frame_start, frame_end;
   fcf_tag_type        tag0_ff, tag0_in;

   assign req_bus.ready = occ_ff < OCC_W'(FD);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign sample_acc    = req_fire && (req_bus.req_type == REQ_SAMPLE);
   assign coef_acc      = req_fire && (req_bus.req_type == REQ_COEF);

   // zero frame length means a full 2^16-sample frame
   assign frame_span   = (frame_len_ff == '0) ? {1'b1, {FRAME_W{1'b0}}} : {1'b0, frame_len_ff};
   assign pos_next     = {1'b0, frame_pos_ff} + 1'b1;
   assign frame_start  = frame_pos_ff == '0;
   assign frame_end    = pos_next >= frame_span;
   assign frame_pos_in = !sample_acc ? frame_pos_ff :
                         (frame_end ? '0 : pos_next[FRAME_W-1:0]);

   assign tag0_in.valid = sample_acc;
   assign tag0_in.last  = frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= '0;
         tag0_ff      <= '0;
      end else begin
         frame_pos_ff <= frame_pos_in;
         tag0_ff      <= tag0_in;
      end
   end

   // ---------------- tap cell chain ----------------
   logic signed [SAMPLE_BITS-1:0] hist_i [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS];
   logic signed [PW-1:0]          prod_i [LEAVES];
   logic signed [PW-1:0]          prod_q [LEAVES];

   generate
      for (genvar k = 0; k < LEAVES; k++) begin : g_cell
         if (k < MAX_TAPS) begin : g_tap
            logic signed [SAMPLE_BITS-1:0] prev_i, prev_q;
            if (k == 0) begin : g_head
               assign prev_i = req_bus.sample_i;
               assign prev_q = req_bus.sample_q;
            end else begin : g_link
               assign prev_i = hist_i[k-1];
               assign prev_q = hist_q[k-1];
            end
            fcf_tap_cell #(
               .SAMPLE_BITS (SAMPLE_BITS),
               .COEF_BITS   (COEF_BITS),
               .IDX         (k)
            ) u_cell (
               .clock      (clock),
               .reset      (reset),
               .shift      (sample_acc),
               .clear      (frame_start),
               .prev_i     (prev_i),
               .prev_q     (prev_q),
               .coef_we    (coef_acc),
               .coef_index (req_bus.coef_index),
               .coef_value (req_bus.coef_value),
               .tap_count  (tap_count_ff),
               .hist_i     (hist_i[k]),
               .hist_q     (hist_q[k]),
               .prod_i     (prod_i[k]),
               .prod_q     (prod_q[k])
            );
         end else begin : g_pad
            assign prod_i[k] = '0;
            assign prod_q[k] = '0;
         end
      end
   endgenerate

   // ---------------- summation ----------------
   fcf_tag_type             root_tag;
   logic signed [ACC_W-1:0] sum_i, sum_q;

   fcf_add_tree #(
      .LEAVES (LEAVES),
      .IN_W   (PW),
      .ACC_W  (ACC_W)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag0_ff),
      .leaf_i  (prod_i),
      .leaf_q  (prod_q),
      .tag_out (root_tag),
      .sum_i   (sum_i),
      .sum_q   (sum_q)
   );

   // ---------------- output FIFO ----------------
   fcf_out_type       fifo_ff [FD];
   fcf_out_type       push_word;
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]  fcnt_ff;
   logic              push, pop;

   assign push_word.out_i      = shift_sat(sum_i);
   assign push_word.out_q      = shift_sat(sum_q);
   assign push_word.frame_last = root_tag.last;

   assign push = root_tag.valid;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   // occupancy counts words in flight plus words held in the FIFO
   always_comb begin
      occ_in = occ_ff;
      if (sample_acc && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (!sample_acc && pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fcnt_ff   <= '0;
         occ_ff    <= '0;
      end else begin
         occ_ff <= occ_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fcnt_ff <= fcnt_ff + 1'b1;
         end else if (!push && pop) begin
            fcnt_ff <= fcnt_ff - 1'b1;
         end
      end
   end

   assign rsp_bus.valid      = fcnt_ff != '0;
   assign rsp_bus.out_i      = fifo_ff[rd_ptr_ff].out_i;
   assign rsp_bus.out_q      = fifo_ff[rd_ptr_ff].out_q;
   assign rsp_bus.frame_last = fifo_ff[rd_ptr_ff].frame_last;

endmodule

@@ src/fcf_tap_cell.sv @@
// One tap cell: holds one I/Q history sample and one coefficient, passes the
// sample on to the next cell and registers both rail products. Depends on fcf_pkg.
module fcf_tap_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18,
   parameter int IDX         = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      shift,
   input  logic                                      clear,
   input  logic signed [SAMPLE_BITS-1:0]             prev_i,
   input  logic signed [SAMPLE_BITS-1:0]             prev_q,
   input  logic                                      coef_we,
   input  logic [fcf_pkg::COEF_IDX_W-1:0]            coef_index,
   input  logic signed [COEF_BITS-1:0]               coef_value,
   input  logic [fcf_pkg::TAPCNT_W-1:0]              tap_count,
   output logic signed [SAMPLE_BITS-1:0]             hist_i,
   output logic signed [SAMPLE_BITS-1:0]             hist_q,
   output logic signed [SAMPLE_BITS+COEF_BITS-1:0]   prod_i,
   output logic signed [SAMPLE_BITS+COEF_BITS-1:0]   prod_q
);
   import fcf_pkg::*;

   localparam int PW = SAMPLE_BITS + COEF_BITS;

   logic signed [SAMPLE_BITS-1:0] hist_i_ff, hist_i_in;
   logic signed [SAMPLE_BITS-1:0] hist_q_ff, hist_q_in;
   logic signed [COEF_BITS-1:0]   tap_ff, tap_in;
   logic signed [PW-1:0]          prod_i_ff, prod_q_ff;
   logic                          tap_use;

   always_comb begin
      hist_i_in = hist_i_ff;
      hist_q_in = hist_q_ff;
      if (shift) begin
         // a new frame starts from empty history; the head cell takes the sample
         if (clear && IDX != 0) begin
            hist_i_in = '0;
            hist_q_in = '0;
         end else begin
            hist_i_in = prev_i;
            hist_q_in = prev_q;
         end
      end
   end

   assign tap_in  = (coef_we && 32'(coef_index) == IDX) ? coef_value : tap_ff;
   assign tap_use = 32'(tap_count) > IDX;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_i_ff <= '0;
         hist_q_ff <= '0;
         tap_ff    <= '0;
      end else begin
         hist_i_ff <= hist_i_in;
         hist_q_ff <= hist_q_in;
         tap_ff    <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_i_ff <= tap_use ? PW'(hist_i_in * tap_ff) : '0;
      prod_q_ff <= tap_use ? PW'(hist_q_in * tap_ff) : '0;
   end

   assign hist_i = hist_i_ff;
   assign hist_q = hist_q_ff;
   assign prod_i = prod_i_ff;
   assign prod_q = prod_q_ff;

endmodule

@@ src/fcf_add_tree.sv @@
// Registered binary adder tree summing the tap products of both rails, with a
// register at every level and a matching tag delay line. Depends on fcf_pkg.
module fcf_add_tree #(
   parameter int LEAVES = 32,
   parameter int IN_W   = 34,
   parameter int ACC_W  = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fcf_pkg::fcf_tag_type       tag_in,
   input  logic signed [IN_W-1:0]     leaf_i [LEAVES],
   input  logic signed [IN_W-1:0]     leaf_q [LEAVES],
   output fcf_pkg::fcf_tag_type       tag_out,
   output logic signed [ACC_W-1:0]    sum_i,
   output logic signed [ACC_W-1:0]    sum_q
);
   import fcf_pkg::*;

   localparam int LVL = $clog2(LEAVES);

   generate
      if (LVL == 0) begin : g_single
         assign tag_out = tag_in;
         assign sum_i   = ACC_W'(leaf_i[0]);
         assign sum_q   = ACC_W'(leaf_q[0]);
      end else begin : g_tree
         // heap layout: node 1 is the root, node n adds nodes 2n and 2n+1;
         // indexes at or above LEAVES are the leaves themselves
         logic signed [ACC_W-1:0] node_i_ff [1:LEAVES-1];
         logic signed [ACC_W-1:0] node_q_ff [1:LEAVES-1];
         fcf_tag_type             tag_ff [LVL];

         for (genvar n = 1; n < LEAVES; n++) begin : g_node
            logic signed [ACC_W-1:0] a_i, b_i, a_q, b_q;
            if (2 * n >= LEAVES) begin : g_bottom
               assign a_i = ACC_W'(leaf_i[2 * n - LEAVES]);
               assign b_i = ACC_W'(leaf_i[2 * n + 1 - LEAVES]);
               assign a_q = ACC_W'(leaf_q[2 * n - LEAVES]);
               assign b_q = ACC_W'(leaf_q[2 * n + 1 - LEAVES]);
            end else begin : g_inner
               assign a_i = node_i_ff[2 * n];
               assign b_i = node_i_ff[2 * n + 1];
               assign a_q = node_q_ff[2 * n];
               assign b_q = node_q_ff[2 * n + 1];
            end
            always_ff @(posedge clock) begin
               node_i_ff[n] <= a_i + b_i;
               node_q_ff[n] <= a_q + b_q;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               for (int k = 0; k < LVL; k++) begin
                  tag_ff[k] <= '0;
               end
            end else begin
               tag_ff[0] <= tag_in;
               for (int k = 1; k < LVL; k++) begin
                  tag_ff[k] <= tag_ff[k-1];
               end
            end
         end

         assign tag_out = tag_ff[LVL-1];
         assign sum_i   = node_i_ff[1];
         assign sum_q   = node_q_ff[1];
      end
   endgenerate

endmodule

@@ src/fcf_checker.sv @@
// Port-level checks for the framed complex FIR filter, bound to the top level.
// Depends on fcf_pkg and framed_complex_fir_filter.
module fcf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fcf_pkg::OUT_BITS-1:0]      rsp_out_i,
   input logic [fcf_pkg::OUT_BITS-1:0]      rsp_out_q,
   input logic                              rsp_frame_last,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [fcf_pkg::CSR_ADDR_W-1:0]    paddr,
   input logic [fcf_pkg::CSR_DATA_W-1:0]    pwdata,
   input logic [fcf_pkg::CSR_DATA_W-1:0]    prdata
);
   import fcf_pkg::*;

   // nothing is left in the output FIFO across a reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a held response keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_i) &&
         $stable(rsp_out_q) && $stable(rsp_frame_last))
      else $error("stalled response changed");

   // input back-pressure only ever comes from results waiting at the output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // tap count reads back what was just written
   a_tap_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[2] == REG_TAP_COUNT) ##1
      (psel && !pwrite && paddr[2] == REG_TAP_COUNT)
      |-> prdata[TAPCNT_W-1:0] == $past(pwdata[TAPCNT_W-1:0]))
      else $error("tap count readback mismatch");

endmodule

bind framed_complex_fir_filter fcf_checker u_fcf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_out_i      (rsp_bus.out_i),
   .rsp_out_q      (rsp_bus.out_q),
   .rsp_frame_last (rsp_bus.frame_last),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata)
);
